// ----- sv/assert_macros.svh -----
// Shared assertion macros; clk and rst_n must be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, outside reset.
`define PPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ppt assertion failed");

// Check a property on every rising edge, reset included.
`define PPT_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ppt assertion failed");

`endif

// ----- sv/ppt_pkg.sv -----
package ppt_pkg;

  localparam int COORD_BITS     = 16;
  localparam int COEF_FRAC_BITS = 32;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int COEF_W         = 48;
  localparam int OUT_W          = 32;
  localparam int REG_N          = 8;
  localparam int IDX_W          = 3;

  localparam int PROD_W  = COEF_W + COORD_BITS;
  localparam int SUM_W   = PROD_W + 2;
  localparam int NM_W    = SUM_W + OUT_FRAC_BITS;
  localparam int REM_W   = SUM_W + 1;
  localparam int N_CELLS = OUT_W;

  localparam logic [SUM_W-1:0] W_ONE   = SUM_W'(1) << COEF_FRAC_BITS;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [IDX_W-1:0] {
    REG_SCALE_XX, REG_SKEW_XY, REG_SHIFT_X, REG_SKEW_YX,
    REG_SCALE_YY, REG_SHIFT_Y, REG_PERSP_X, REG_PERSP_Y
  } ppt_reg_t;

  typedef logic [COEF_W-1:0] ppt_coef_t [REG_N];

  // Data handed from one divider cell to the next.
  typedef struct packed {
    logic              valid;
    logic              neg_x;
    logic              neg_y;
    logic              ovf_x;
    logic              ovf_y;
    logic              inf;
    logic [SUM_W-1:0]  wm;
    logic [REM_W-1:0]  rem_x;
    logic [REM_W-1:0]  rem_y;
    logic [OUT_W-1:0]  lq_x;
    logic [OUT_W-1:0]  lq_y;
  } ppt_cell_t;

endpackage

// ----- sv/ppt_front.sv -----
module ppt_front import ppt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] pt_x,
  input  logic [COORD_BITS-1:0] pt_y,
  input  ppt_coef_t             coef,
  output ppt_cell_t             cell_o
);

  logic                  v0_r, v1_r, v2_r;
  logic [COORD_BITS-1:0] x0_r, y0_r;
  logic signed [PROD_W-1:0] p_r [6];
  logic signed [COEF_W-1:0] sx1_r, sy1_r;
  logic signed [SUM_W-1:0] w2_r, nx2_r, ny2_r;
  logic [SUM_W-1:0] wm, mx, my;
  logic [NM_W-1:0]  nmx, nmy;
  ppt_cell_t cell_nxt, cell_r;

  // magnitudes, numerators scaled to output format, overflow check
  always_comb begin
    wm  = w2_r[SUM_W-1]  ? SUM_W'(-w2_r)  : SUM_W'(w2_r);
    mx  = nx2_r[SUM_W-1] ? SUM_W'(-nx2_r) : SUM_W'(nx2_r);
    my  = ny2_r[SUM_W-1] ? SUM_W'(-ny2_r) : SUM_W'(ny2_r);
    nmx = {mx, {OUT_FRAC_BITS{1'b0}}};
    nmy = {my, {OUT_FRAC_BITS{1'b0}}};
    cell_nxt.valid = v2_r;
    cell_nxt.neg_x = nx2_r[SUM_W-1] ^ w2_r[SUM_W-1];
    cell_nxt.neg_y = ny2_r[SUM_W-1] ^ w2_r[SUM_W-1];
    // quotient needs more than OUT_W bits: compare at full width of wm << OUT_W
    cell_nxt.ovf_x = {{(OUT_W-OUT_FRAC_BITS){1'b0}}, nmx} >= {wm, {OUT_W{1'b0}}};
    cell_nxt.ovf_y = {{(OUT_W-OUT_FRAC_BITS){1'b0}}, nmy} >= {wm, {OUT_W{1'b0}}};
    cell_nxt.inf   = (w2_r == '0);
    cell_nxt.wm    = wm;
    cell_nxt.rem_x = REM_W'(nmx >> OUT_W);
    cell_nxt.rem_y = REM_W'(nmy >> OUT_W);
    cell_nxt.lq_x  = nmx[OUT_W-1:0];
    cell_nxt.lq_y  = nmy[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      cell_r <= cell_nxt;
    end
    if (adv) begin
      x0_r  <= pt_x;
      y0_r  <= pt_y;
      p_r[0] <= $signed(coef[REG_PERSP_X]) * $signed(x0_r);
      p_r[1] <= $signed(coef[REG_PERSP_Y]) * $signed(y0_r);
      p_r[2] <= $signed(coef[REG_SCALE_XX]) * $signed(x0_r);
      p_r[3] <= $signed(coef[REG_SKEW_XY]) * $signed(y0_r);
      p_r[4] <= $signed(coef[REG_SKEW_YX]) * $signed(x0_r);
      p_r[5] <= $signed(coef[REG_SCALE_YY]) * $signed(y0_r);
      sx1_r <= $signed(coef[REG_SHIFT_X]);
      sy1_r <= $signed(coef[REG_SHIFT_Y]);
      w2_r  <= SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + $signed(W_ONE);
      nx2_r <= SUM_W'(p_r[2]) + SUM_W'(p_r[3]) + SUM_W'(sx1_r);
      ny2_r <= SUM_W'(p_r[4]) + SUM_W'(p_r[5]) + SUM_W'(sy1_r);
    end
  end

  assign cell_o = cell_r;

endmodule

// ----- sv/ppt_div_cell.sv -----
module ppt_div_cell import ppt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      adv,
  input  ppt_cell_t cell_i,
  output ppt_cell_t cell_o
);

  ppt_cell_t cell_nxt, cell_r;
  logic [REM_W-1:0] sx, sy;
  logic gx, gy;

  // one restoring step per lane: bring in the next numerator bit, try subtract
  always_comb begin
    sx = {cell_i.rem_x[REM_W-2:0], cell_i.lq_x[OUT_W-1]};
    sy = {cell_i.rem_y[REM_W-2:0], cell_i.lq_y[OUT_W-1]};
    gx = sx >= REM_W'(cell_i.wm);
    gy = sy >= REM_W'(cell_i.wm);
    cell_nxt = cell_i;
    cell_nxt.rem_x = gx ? sx - REM_W'(cell_i.wm) : sx;
    cell_nxt.rem_y = gy ? sy - REM_W'(cell_i.wm) : sy;
    cell_nxt.lq_x  = {cell_i.lq_x[OUT_W-2:0], gx};
    cell_nxt.lq_y  = {cell_i.lq_y[OUT_W-2:0], gy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else if (adv) begin
      cell_r.valid <= cell_nxt.valid;
    end
    if (adv) begin
      cell_r.neg_x <= cell_nxt.neg_x;
      cell_r.neg_y <= cell_nxt.neg_y;
      cell_r.ovf_x <= cell_nxt.ovf_x;
      cell_r.ovf_y <= cell_nxt.ovf_y;
      cell_r.inf   <= cell_nxt.inf;
      cell_r.wm    <= cell_nxt.wm;
      cell_r.rem_x <= cell_nxt.rem_x;
      cell_r.rem_y <= cell_nxt.rem_y;
      cell_r.lq_x  <= cell_nxt.lq_x;
      cell_r.lq_y  <= cell_nxt.lq_y;
    end
  end

  assign cell_o = cell_r;

endmodule

// ----- sv/projective_point_transform.sv -----
// Projective point transform: maps one point of signed pixel coordinates per word
// through a 3x3 homography (bottom-right entry one) with signed Q16.32 coefficients,
// giving Q16.16 results truncated toward zero, saturated with clipped set, or zero
// with at_infinity set when the denominator is exactly zero. It takes one word every
// clock while the output is not stalled; from input accept to output valid a word
// passes an input register, the coefficient multipliers, the sum adders, a
// sign/overflow stage, 32 divider cells (one quotient bit each, both coordinates at
// once) and the output register. The whole pipeline holds while a finished word waits
// on out_tready, so in_tready follows out_tready when the output register is full.
// Write the coefficients only while the pipeline is empty.
module projective_point_transform import ppt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [31:0]       in_tdata,   // point_x[15:0], point_y[31:16]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // out_x[31:0], out_y[63:32]
  output logic [1:0]        out_tuser,  // at_infinity[0], clipped[1]
  input  logic              cfg_we,
  input  logic [IDX_W-1:0]  cfg_addr,
  input  logic [COEF_W-1:0] cfg_wdata
);

  ppt_coef_t coef_r;
  logic      adv;
  ppt_cell_t chain [N_CELLS+1];
  ppt_cell_t last;

  logic              vo_r;
  logic [OUT_W-1:0]  ox_r, oy_r, ox_nxt, oy_nxt;
  logic              inf_r, clip_r, clip_nxt, cx, cy;

  // advance everything unless a finished word is stuck at the output
  assign adv       = !vo_r || out_tready;
  assign in_tready = adv;

  // coefficient registers; both scale terms come out of reset at one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_N; i++)
        coef_r[i] <= (i == int'(REG_SCALE_XX) || i == int'(REG_SCALE_YY)) ? COEF_ONE : '0;
    end else if (cfg_we) begin
      coef_r[cfg_addr] <= cfg_wdata;
    end
  end

  ppt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_tvalid),
    .pt_x     (in_tdata[COORD_BITS-1:0]),
    .pt_y     (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .coef     (coef_r),
    .cell_o   (chain[0])
  );

  // divider chain: cell k settles quotient bit OUT_W-1-k
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    ppt_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .cell_i (chain[k]),
      .cell_o (chain[k+1])
    );
  end

  assign last = chain[N_CELLS];

  // saturate, apply sign, zero the outputs at infinity
  always_comb begin
    cx = last.ovf_x || (last.lq_x > (last.neg_x ? SAT_NEG : SAT_POS));
    cy = last.ovf_y || (last.lq_y > (last.neg_y ? SAT_NEG : SAT_POS));
    ox_nxt = cx ? (last.neg_x ? SAT_NEG : SAT_POS)
                : (last.neg_x ? OUT_W'(-last.lq_x) : last.lq_x);
    oy_nxt = cy ? (last.neg_y ? SAT_NEG : SAT_POS)
                : (last.neg_y ? OUT_W'(-last.lq_y) : last.lq_y);
    clip_nxt = cx || cy;
    if (last.inf) begin
      ox_nxt   = '0;
      oy_nxt   = '0;
      clip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (adv) begin
      vo_r <= last.valid;
    end
    if (adv) begin
      ox_r   <= ox_nxt;
      oy_r   <= oy_nxt;
      inf_r  <= last.inf;
      clip_r <= clip_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tuser  = {clip_r, inf_r};

endmodule

// ----- sv/ppt_checker.sv -----
`include "assert_macros.svh"

module ppt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // a waiting word holds
  `PPT_ASSERT(a_hold, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
  // the pipeline only stalls on a full, unaccepted output
  `PPT_ASSERT(a_ready, !in_tready |-> out_tvalid && !out_tready)
  // infinity gives zero coordinates and no clip
  `PPT_ASSERT(a_inf, out_tvalid && out_tuser[0] |-> out_tdata == 64'd0 && !out_tuser[1])
  // a clipped word carries at least one saturated coordinate
  `PPT_ASSERT(a_clip, out_tvalid && out_tuser[1] |-> out_tdata[31:0] == 32'h7FFFFFFF || out_tdata[31:0] == 32'h80000000 || out_tdata[63:32] == 32'h7FFFFFFF || out_tdata[63:32] == 32'h80000000)

endmodule

bind projective_point_transform ppt_checker u_ppt_checker (.*);
